>>> src/wlzd_pkg.sv
// shared constants, types and control structs of the word lzss decoder
package wlzd_pkg;

    // word and history geometry
    localparam int WORD_W     = 16;
    localparam int HIST_DEPTH = 256;
    localparam int HIST_AW    = 8;
    localparam int LANES      = 4;
    localparam int LANE_AW    = 2;
    localparam int CNT_W      = 3;
    localparam int DESCR_W    = 16;
    localparam int BL_W       = 5;
    localparam int BIT_AW     = 4;
    localparam int LEN_W      = 9;

    // stream packing
    localparam int S_TDATA_W = 16;
    localparam int M_PACK_W  = LANES * WORD_W + CNT_W;
    localparam int M_TDATA_W = ((M_PACK_W + 7) / 8) * 8;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } state_t;

    // one push into the result packer
    typedef struct packed {
        logic              push;
        logic              has_word;
        logic              close;
        logic              stream_end;
        logic [WORD_W-1:0] word;
    } pk_push_t;

    // packer status back to the sequencer
    typedef struct packed {
        logic             pending;
        logic             room;
        logic [CNT_W-1:0] count;
    } pk_stat_t;

endpackage

>>> src/wlzd_history.sv
// 256-word history memory with valid bits and same-cycle write forwarding
module wlzd_history (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [wlzd_pkg::HIST_AW-1:0] rd_addr,
    input  logic                         wr_en,
    input  logic [wlzd_pkg::HIST_AW-1:0] wr_addr,
    input  logic [wlzd_pkg::WORD_W-1:0]  wr_data,
    output logic [wlzd_pkg::WORD_W-1:0]  rd_data
);
    import wlzd_pkg::*;

    logic [WORD_W-1:0]     mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] vld_reg;
    logic [HIST_DEPTH-1:0] vld_next;
    logic [WORD_W-1:0]     q_reg;
    logic                  q_vld_reg;
    logic                  fwd_reg;
    logic [WORD_W-1:0]     fwd_data_reg;

    // memory array: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    // valid bits, an unwritten entry reads as zero
    always_comb begin
        vld_next = vld_reg;
        if (wr_en) begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
            if (rd_en) begin
                q_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // catch a read of the entry written in the same cycle
    always_ff @(posedge aclk) begin
        fwd_reg      <= rd_en && wr_en && (rd_addr == wr_addr);
        fwd_data_reg <= wr_data;
    end

    always_comb begin
        if (fwd_reg) begin
            rd_data = fwd_data_reg;
        end else if (q_vld_reg) begin
            rd_data = q_reg;
        end else begin
            rd_data = '0;
        end
    end

endmodule

>>> src/wlzd_packer.sv
// gathers decoded words into four-lane results and holds the output register
module wlzd_packer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  wlzd_pkg::pk_push_t             pk_push,
    output wlzd_pkg::pk_stat_t             pk_stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_word0, out_word1, out_word2, out_word3, word_count, zero pad
    output logic [wlzd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,   // run_last
    output logic                           m_tuser    // stream_end
);
    import wlzd_pkg::*;

    logic [WORD_W-1:0]    lane_reg  [LANES];
    logic [WORD_W-1:0]    lane_next [LANES];
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 pend_reg;
    logic                 pend_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 end_reg;
    logic                 end_next;
    logic                 out_free;
    logic                 move;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 m_tuser_reg;
    logic [M_PACK_W-1:0]  pack;

    // output register frees when empty or being taken
    assign out_free = !m_tvalid_reg || m_tready;
    assign move     = pend_reg && out_free;

    assign pk_stat.pending = pend_reg;
    assign pk_stat.room    = !pend_reg || out_free;
    assign pk_stat.count   = cnt_reg;

    // accumulate lanes, a finished group waits in pending
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            lane_next[i] = move ? '0 : lane_reg[i];
        end
        cnt_next  = move ? '0 : cnt_reg;
        pend_next = move ? 1'b0 : pend_reg;
        last_next = move ? 1'b0 : last_reg;
        end_next  = move ? 1'b0 : end_reg;
        if (pk_push.push) begin
            if (pk_push.has_word) begin
                lane_next[cnt_next[LANE_AW-1:0]] = pk_push.word;
                cnt_next  = cnt_next + CNT_W'(1);
                pend_next = (cnt_next == CNT_W'(LANES)) || pk_push.close;
                last_next = pk_push.close;
                end_next  = 1'b0;
            end else begin
                pend_next = 1'b1;
                last_next = 1'b1;
                end_next  = pk_push.stream_end;
            end
        end
    end

    always_comb begin
        pack = '0;
        for (int i = 0; i < LANES; i++) begin
            pack[i*WORD_W +: WORD_W] = lane_reg[i];
        end
        pack[LANES*WORD_W +: CNT_W] = cnt_reg;
    end

    // lane payload, unused lanes start at zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANES; i++) begin
                lane_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < LANES; i++) begin
                lane_reg[i] <= lane_next[i];
            end
        end
        if (move) begin
            m_tdata_reg <= M_TDATA_W'(pack);
            m_tlast_reg <= last_reg;
            m_tuser_reg <= end_reg;
        end
    end

    // group control and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            last_reg     <= 1'b0;
            end_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            last_reg <= last_next;
            end_reg  <= end_next;
            if (move) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // an empty result is only ever the end marker
    a_empty_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && cnt_reg == '0) |-> (end_reg && last_reg))
        else $error("empty result group without end marker");

    // a group never holds more than four words
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(LANES))
        else $error("lane count overflow");

    // no word arrives while a full group is stuck
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && !out_free) |-> !pk_push.push)
        else $error("push into a blocked group");
`endif

endmodule

>>> src/word_lzss_decoder_core.sv
// top level of the word lzss decoder: descriptor handling and copy sequencer
//
// Usage:
//   s_ channel carries the compressed stream, one 16-bit word per transaction
//   (s_tdata[15:0]). m_ channel carries results: four decoded words and a
//   word count in m_tdata, run_last on m_tlast, stream_end on m_tuser.
//   A descriptor word gives no result. A literal gives one result of one word.
//   A match of n+1 words gives ceil((n+1)/4) results, the last with tlast.
//   An end marker gives one result with count 0, tlast and tuser set.
// Timing:
//   a literal or end marker result passes the packer registers, then the
//   output register to m_; back-to-back literals run at one word per cycle
//   while m_tready is high. A match holds the input; history reads run at
//   one word per cycle (data the cycle after issue), pausing at group ends.
// Reset:
//   aresetn (synchronous, active low) clears the history to zero through its
//   valid bits at once, and the next word is taken as a descriptor.
// Stall:
//   while m_tready is low a finished result waits in the output register,
//   one more group waits in the packer, and the copy and input then hold.
module word_lzss_decoder_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // in_word
    input  logic [wlzd_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_word0, out_word1, out_word2, out_word3, word_count, zero pad
    output logic [wlzd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,   // run_last
    output logic                           m_tuser    // stream_end
);
    import wlzd_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [WORD_W-1:0]  desc_reg;
    logic [WORD_W-1:0]  desc_next;
    logic [BL_W-1:0]    bits_left_reg;
    logic [BL_W-1:0]    bits_left_next;
    logic [HIST_AW-1:0] wp_reg;
    logic [HIST_AW-1:0] wp_next;
    logic [HIST_AW-1:0] src_reg;
    logic [HIST_AW-1:0] src_next;
    logic [LEN_W-1:0]   issue_left_reg;
    logic [LEN_W-1:0]   issue_left_next;
    logic [LEN_W-1:0]   write_left_reg;
    logic [LEN_W-1:0]   write_left_next;
    logic               inflight_reg;
    logic               inflight_next;

    logic               s_fire;
    logic               need_desc;
    logic               desc_bit;
    logic               is_lit;
    logic               is_match;
    logic               is_end;
    logic               is_copy;
    logic [7:0]         len_byte;
    logic [7:0]         off_byte;
    logic               last_arrival;
    logic               closes;
    logic               issue;
    logic               wr_en;
    logic [WORD_W-1:0]  wr_data;
    logic [WORD_W-1:0]  hist_rd_data;
    pk_push_t           pk_push;
    pk_stat_t           pk_stat;

    // token decode of the accepted word
    assign len_byte  = s_tdata[7:0];
    assign off_byte  = s_tdata[15:8];
    assign s_fire    = s_tvalid && s_tready;
    assign need_desc = (bits_left_reg == '0) || (bits_left_reg > BL_W'(DESCR_W));
    assign desc_bit  = desc_reg[BIT_AW'(bits_left_reg - BL_W'(1))];
    assign is_lit    = s_fire && !need_desc && !desc_bit;
    assign is_match  = s_fire && !need_desc && desc_bit;
    assign is_end    = is_match && (len_byte == '0);
    assign is_copy   = is_match && (len_byte != '0);

    assign last_arrival = inflight_reg && (write_left_reg == LEN_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (is_copy) begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY: begin
                if (last_arrival) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs: input ready and read issue
    always_comb begin
        s_tready = 1'b0;
        issue    = 1'b0;
        closes   = inflight_reg &&
                   ((pk_stat.count == CNT_W'(LANES - 1)) || (write_left_reg == LEN_W'(1)));
        unique case (state_reg)
            ST_IDLE: s_tready = pk_stat.room;
            ST_COPY: issue    = (issue_left_reg != '0) && pk_stat.room && !closes;
            default: s_tready = 1'b0;
        endcase
    end

    // history write and packer push
    assign wr_en   = is_lit || inflight_reg;
    assign wr_data = inflight_reg ? hist_rd_data : s_tdata;

    assign pk_push.push       = is_lit || is_end || inflight_reg;
    assign pk_push.has_word   = !is_end;
    assign pk_push.close      = is_lit || last_arrival;
    assign pk_push.stream_end = is_end;
    assign pk_push.word       = wr_data;

    // descriptor and pointer updates
    always_comb begin
        desc_next       = desc_reg;
        bits_left_next  = bits_left_reg;
        wp_next         = wp_reg;
        src_next        = src_reg;
        issue_left_next = issue_left_reg;
        write_left_next = write_left_reg;
        inflight_next   = issue;
        if (s_fire) begin
            if (need_desc) begin
                desc_next      = s_tdata;
                bits_left_next = BL_W'(DESCR_W);
            end else if (is_end) begin
                bits_left_next = '0;
            end else begin
                bits_left_next = bits_left_reg - BL_W'(1);
            end
        end
        if (is_copy) begin
            src_next        = wp_reg + off_byte;
            issue_left_next = {1'b0, len_byte} + LEN_W'(1);
            write_left_next = {1'b0, len_byte} + LEN_W'(1);
        end
        if (issue) begin
            src_next        = src_reg + HIST_AW'(1);
            issue_left_next = issue_left_reg - LEN_W'(1);
        end
        if (wr_en) begin
            wp_next = wp_reg + HIST_AW'(1);
        end
        if (inflight_reg) begin
            write_left_next = write_left_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            desc_reg       <= '0;
            bits_left_reg  <= '0;
            wp_reg         <= '0;
            src_reg        <= '0;
            issue_left_reg <= '0;
            write_left_reg <= '0;
            inflight_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            desc_reg       <= desc_next;
            bits_left_reg  <= bits_left_next;
            wp_reg         <= wp_next;
            src_reg        <= src_next;
            issue_left_reg <= issue_left_next;
            write_left_reg <= write_left_next;
            inflight_reg   <= inflight_next;
        end
    end

    // history memory
    wlzd_history u_history (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (issue),
        .rd_addr (src_reg),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_data),
        .rd_data (hist_rd_data)
    );

    // result packer and output register
    wlzd_packer u_packer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pk_push  (pk_push),
        .pk_stat  (pk_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // a read in flight only exists during a copy
    a_inflight_in_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg |-> (state_reg == ST_COPY))
        else $error("history read outside copy");

    // reads issued never run ahead of writes still owed
    a_issue_le_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> (issue_left_reg <= write_left_reg))
        else $error("copy counters out of step");

    // an arriving copy word always finds room in the packer
    a_arrival_room: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg |-> pk_stat.room)
        else $error("copy word arrived with packer blocked");

    // the copy ends exactly when the last owed word is written
    a_copy_done: assert property (@(posedge aclk) disable iff (!aresetn)
        last_arrival |=> (state_reg == ST_IDLE && !inflight_reg))
        else $error("copy did not finish on last word");
`endif

endmodule

>>> test/tb_word_lzss_decoder_core.sv
// testbench for the word lzss decoder core: directed table, random streams, self-checking
module tb_word_lzss_decoder_core;
    import wlzd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_WORDS  = 220;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 64;
    localparam int PRESS_HOLD  = 400;
    localparam int MAX_REPORTS = 10;

    // one decoded result as the block presents it
    typedef struct packed {
        logic [WORD_W-1:0] w3;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w0;
        logic [CNT_W-1:0]  cnt;
        logic              last;
        logic              fin;
    } dec_res_t;

    // one row of the directed stimulus table
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              typed;
        dec_res_t          res;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    word_lzss_decoder_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // decoder mirror state
    logic [WORD_W-1:0] dec_desc;
    logic [BL_W-1:0]   dec_left;
    logic [WORD_W-1:0] dec_hist [HIST_DEPTH];
    logic [HIST_AW-1:0] dec_wp;

    dec_res_t  decoded_q[$];
    stim_row_t table_q[$];

    int n_sent = 0;
    int n_directed = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_reported = 0;
    int n_literals = 0;
    int n_copies = 0;
    int n_copy_words = 0;
    int n_ends = 0;
    int cycles = 0;

    bit src_quiet = 1'b0;
    bit sink_quiet = 1'b0;
    bit pressure_req = 1'b0;
    bit pressure_done = 1'b0;
    int hold_left = 0;

    function automatic dec_res_t mk_res(logic [WORD_W-1:0] w0, int cnt,
                                        logic last, logic fin);
        dec_res_t r;
        r      = '0;
        r.w0   = w0;
        r.cnt  = CNT_W'(cnt);
        r.last = last;
        r.fin  = fin;
        return r;
    endfunction

    // mirror of the decoder: consumes one stream word, queues the words it decodes
    task automatic decode_word(input logic [WORD_W-1:0] w);
        logic              flag;
        logic [HIST_AW-1:0] src;
        logic [WORD_W-1:0] lane [LANES];
        logic [WORD_W-1:0] v;
        int                total;
        int                done;
        int                k;
        dec_res_t          r;
        if (dec_left == '0) begin
            dec_desc = w;
            dec_left = BL_W'(DESCR_W);
        end else begin
            flag     = dec_desc[dec_left - BL_W'(1)];
            dec_left = dec_left - BL_W'(1);
            if (!flag) begin
                // literal
                decoded_q.push_back(mk_res(w, 1, 1'b1, 1'b0));
                dec_hist[dec_wp] = w;
                dec_wp           = dec_wp + HIST_AW'(1);
                n_literals++;
            end else if (w[7:0] == 8'h00) begin
                // end marker drops the rest of the descriptor
                decoded_q.push_back(mk_res('0, 0, 1'b1, 1'b1));
                dec_left = '0;
                n_ends++;
            end else begin
                // copy: 256-b words back is b words ahead modulo the window
                total = int'(w[7:0]) + 1;
                done  = 0;
                n_copies++;
                while (done < total) begin
                    k = 0;
                    for (int i = 0; i < LANES; i++) lane[i] = '0;
                    while (k < LANES && done < total) begin
                        src              = dec_wp + w[15:8];
                        v                = dec_hist[src];
                        dec_hist[dec_wp] = v;
                        dec_wp           = dec_wp + HIST_AW'(1);
                        lane[k]          = v;
                        k++;
                        done++;
                    end
                    r      = '0;
                    r.w0   = lane[0];
                    r.w1   = lane[1];
                    r.w2   = lane[2];
                    r.w3   = lane[3];
                    r.cnt  = CNT_W'(k);
                    r.last = (done == total);
                    decoded_q.push_back(r);
                end
                n_copy_words += total;
            end
        end
    endtask

    // sender idle length: mostly none or short, sometimes long
    function automatic int idle_gap();
        int r;
        if (src_quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one word and wait for its transaction
    task automatic send_word(input logic [WORD_W-1:0] w, input logic typed,
                             input dec_res_t typed_res);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        decode_word(w);
        if (typed) begin
            void'(decoded_q.pop_back());
            decoded_q.push_back(typed_res);
        end
        n_sent++;
    endtask

    task automatic add_row(input logic [WORD_W-1:0] w, input logic typed, input dec_res_t r);
        stim_row_t row;
        row.word  = w;
        row.typed = typed;
        row.res   = r;
        table_q.push_back(row);
    endtask

    // one random stream: descriptor then tokens, mostly well formed
    task automatic send_random_stream();
        logic [WORD_W-1:0] desc;
        logic [7:0]        len;
        logic [7:0]        ofs;
        int                r;
        src_quiet  = ($urandom_range(0, 3) == 0);
        sink_quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
            // noise: plain random words
            repeat ($urandom_range(1, 8)) send_word(WORD_W'($urandom), 1'b0, '0);
        end else begin
            desc = WORD_W'($urandom);
            send_word(desc, 1'b0, '0);
            for (int i = DESCR_W - 1; i >= 0; i--) begin
                if (!desc[i]) begin
                    send_word(WORD_W'($urandom), 1'b0, '0);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 8) begin
                        send_word({8'($urandom_range(0, 255)), 8'h00}, 1'b0, '0);
                        break;
                    end
                    len = (r < 12) ? 8'($urandom_range(16, 255)) : 8'($urandom_range(1, 15));
                    ofs = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(240, 255))
                                                      : 8'($urandom_range(0, 255));
                    send_word({ofs, len}, 1'b0, '0);
                end
            end
        end
    endtask

    // reset, directed table, random streams, drain and verdict
    initial begin
        dec_desc = '0;
        dec_left = '0;
        dec_wp   = '0;
        for (int i = 0; i < HIST_DEPTH; i++) dec_hist[i] = '0;

        // first stream: copy from before the start, literals, overlapping copy, short copy, end
        add_row(16'h8E00, 1'b0, '0);
        add_row(16'h0003, 1'b1, mk_res('0, 4, 1'b1, 1'b0));
        add_row(16'hFFFF, 1'b1, mk_res(16'hFFFF, 1, 1'b1, 1'b0));
        add_row(16'h0000, 1'b1, mk_res(16'h0000, 1, 1'b1, 1'b0));
        add_row(16'hA5C3, 1'b1, mk_res(16'hA5C3, 1, 1'b1, 1'b0));
        add_row(16'hFF05, 1'b0, '0);
        add_row(16'hFD01, 1'b0, '0);
        add_row(16'h1200, 1'b1, mk_res('0, 0, 1'b1, 1'b1));
        // second stream: longest copy at distance 256, mid copy, literal, overlapping copy, end
        add_row(16'hD800, 1'b0, '0);
        add_row(16'h00FF, 1'b0, '0);
        add_row(16'h7F07, 1'b0, '0);
        add_row(16'h8001, 1'b1, mk_res(16'h8001, 1, 1'b1, 1'b0));
        add_row(16'hFF02, 1'b0, '0);
        add_row(16'h0000, 1'b1, mk_res('0, 0, 1'b1, 1'b1));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (table_q[i]) send_word(table_q[i].word, table_q[i].typed, table_q[i].res);
        n_directed = n_sent;

        // long receiver hold at the start of the random part
        pressure_req = 1'b1;
        while (n_sent < n_directed + RAND_WORDS) send_random_stream();
        s_tvalid <= 1'b0;

        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("sent %0d words (%0d from the table), checked %0d results", n_sent,
                 n_directed, n_checked);
        $display("tokens: %0d literals, %0d copies (%0d words), %0d end markers",
                 n_literals, n_copies, n_copy_words, n_ends);
        if (n_errors == 0 && decoded_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // receiver readiness with random stalls and one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (pressure_req && !pressure_done) begin
            pressure_done <= 1'b1;
            hold_left     <= PRESS_HOLD;
            m_tready      <= 1'b0;
        end else if (!sink_quiet && $urandom_range(0, 99) < 3) begin
            hold_left <= $urandom_range(5, 20);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= sink_quiet || ($urandom_range(0, 99) < 75);
        end
    end

    // result check against the oldest decoded expectation
    always @(posedge aclk) begin
        dec_res_t got;
        dec_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.w0   = m_tdata[0*WORD_W +: WORD_W];
            got.w1   = m_tdata[1*WORD_W +: WORD_W];
            got.w2   = m_tdata[2*WORD_W +: WORD_W];
            got.w3   = m_tdata[3*WORD_W +: WORD_W];
            got.cnt  = m_tdata[LANES*WORD_W +: CNT_W];
            got.last = m_tlast;
            got.fin  = m_tuser;
            n_checked++;
            if (decoded_q.size() == 0) begin
                n_errors++;
                if (n_reported < MAX_REPORTS) begin
                    n_reported++;
                    $display("unexpected result: words %h %h %h %h count %0d last %b end %b",
                             got.w0, got.w1, got.w2, got.w3, got.cnt, got.last, got.fin);
                end
            end else begin
                want = decoded_q.pop_front();
                if (got.w0 !== want.w0 || got.w1 !== want.w1 || got.w2 !== want.w2 ||
                    got.w3 !== want.w3 || got.cnt !== want.cnt || got.last !== want.last ||
                    got.fin !== want.fin) begin
                    n_errors++;
                    if (n_reported < MAX_REPORTS) begin
                        n_reported++;
                        $display("mismatch at result %0d", n_checked);
                        $display("  expected words %h %h %h %h count %0d last %b end %b",
                                 want.w0, want.w1, want.w2, want.w3, want.cnt, want.last,
                                 want.fin);
                        $display("  actual   words %h %h %h %h count %0d last %b end %b",
                                 got.w0, got.w1, got.w2, got.w3, got.cnt, got.last, got.fin);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     decoded_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
